// ===== hdl/asi_pkg.sv =====
`default_nettype none
package asi_pkg;

  // store capacity and compared width
  localparam int MAX_ELEMENTS = 64;
  localparam int VALUE_BITS   = 32;
  localparam int KEY_BITS     = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  // fixed field widths
  localparam int SAMPLE_BITS = 32;
  localparam int POS_BITS    = 6;
  localparam int CNT_BITS    = $clog2(MAX_ELEMENTS + 1);

  // command broadcast along the cell row
  typedef struct packed {
    logic                       load;
    logic                       drain;
    logic signed [KEY_BITS-1:0] key;
    logic [POS_BITS-1:0]        pos;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/asi_stream_if.sv =====
`default_nettype none
interface asi_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [asi_pkg::SAMPLE_BITS-1:0] sample_value;
  logic                                 is_final;

  modport source(output valid, sample_value, is_final, input ready);
  modport sink(input valid, sample_value, is_final, output ready);
endinterface

interface asi_out_if;
  logic                         valid;
  logic                         ready;
  logic [asi_pkg::POS_BITS-1:0] position;
  logic                         run_end;
  logic                         overflowed;

  modport source(output valid, position, run_end, overflowed, input ready);
  modport sink(input valid, position, run_end, overflowed, output ready);
endinterface
`default_nettype wire

// ===== hdl/asi_cell.sv =====
`default_nettype none
module asi_cell (
  input  wire logic                                clk,
  input  wire asi_pkg::cell_cmd_t                  cmd,
  input  wire logic                                occ,
  input  wire logic                                left_gt,
  input  wire logic signed [asi_pkg::KEY_BITS-1:0] left_key,
  input  wire logic [asi_pkg::POS_BITS-1:0]        left_pos,
  input  wire logic signed [asi_pkg::KEY_BITS-1:0] right_key,
  input  wire logic [asi_pkg::POS_BITS-1:0]        right_pos,
  output logic                                     gt,
  output logic signed [asi_pkg::KEY_BITS-1:0]      key,
  output logic [asi_pkg::POS_BITS-1:0]             pos
);

  logic signed [asi_pkg::KEY_BITS-1:0] key_next;
  logic [asi_pkg::POS_BITS-1:0]        pos_next;

  // empty cell or held key above the new one: this cell moves up
  assign gt = !occ || (key > cmd.key);

  // insert takes the new beat or the left neighbour, drain takes the right
  always_comb begin
    key_next = key;
    pos_next = pos;
    if (cmd.load && gt) begin
      if (left_gt) begin
        key_next = left_key;
        pos_next = left_pos;
      end else begin
        key_next = cmd.key;
        pos_next = cmd.pos;
      end
    end else if (cmd.drain) begin
      key_next = right_key;
      pos_next = right_pos;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
    pos <= pos_next;
  end

endmodule
`default_nettype wire

// ===== hdl/argsort_indices_unit.sv =====
`default_nettype none
// argsort_indices_unit: insertion chain of MAX_ELEMENTS cells
// load: one input beat per cycle, each inserted by the cell row as it is taken
// final beat: first result next cycle, then one result per cycle while dout.ready
// is high, fill_count in all; no input is taken while the row drains to cell zero
// reset: clears fill count, drop flag and state; cell contents are left as they are
module argsort_indices_unit (
  input wire logic  clk,
  input wire logic  rst,
  asi_in_if.sink    din,
  asi_out_if.source dout
);

  localparam int N = asi_pkg::MAX_ELEMENTS;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [asi_pkg::CNT_BITS-1:0]  fill_count;
  logic [asi_pkg::CNT_BITS-1:0]  fill_count_next;
  logic                          drop_flag;
  logic                          drop_flag_next;

  logic                          in_beat;
  logic                          out_beat;
  logic                          full;
  asi_pkg::cell_cmd_t            cmd;

  logic                                occ [N];
  logic                                gt  [N];
  logic signed [asi_pkg::KEY_BITS-1:0] key [N];
  logic [asi_pkg::POS_BITS-1:0]        pos [N];

  assign din.ready = (state == ST_LOAD);
  assign in_beat   = din.valid && din.ready;
  assign out_beat  = dout.valid && dout.ready;
  assign full      = (fill_count == asi_pkg::CNT_BITS'(N));

  // broadcast command
  always_comb begin
    cmd.load  = in_beat && !full;
    cmd.drain = out_beat;
    cmd.key   = din.sample_value[asi_pkg::KEY_BITS-1:0];
    cmd.pos   = asi_pkg::POS_BITS'(fill_count);
  end

  // cell row
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                                l_gt;
    logic signed [asi_pkg::KEY_BITS-1:0] l_key;
    logic [asi_pkg::POS_BITS-1:0]        l_pos;
    logic signed [asi_pkg::KEY_BITS-1:0] r_key;
    logic [asi_pkg::POS_BITS-1:0]        r_pos;

    assign occ[i] = (fill_count > asi_pkg::CNT_BITS'(i));

    if (i == 0) begin : g_first
      assign l_gt  = 1'b0;
      assign l_key = '0;
      assign l_pos = '0;
    end else begin : g_mid
      assign l_gt  = gt[i-1];
      assign l_key = key[i-1];
      assign l_pos = pos[i-1];
    end

    if (i == N - 1) begin : g_last
      assign r_key = '0;
      assign r_pos = '0;
    end else begin : g_inner
      assign r_key = key[i+1];
      assign r_pos = pos[i+1];
    end

    asi_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ[i]),
      .left_gt   (l_gt),
      .left_key  (l_key),
      .left_pos  (l_pos),
      .right_key (r_key),
      .right_pos (r_pos),
      .gt        (gt[i]),
      .key       (key[i]),
      .pos       (pos[i])
    );
  end

  // results come straight from cell zero
  assign dout.valid      = (state == ST_DRAIN);
  assign dout.position   = pos[0];
  assign dout.run_end    = (fill_count == asi_pkg::CNT_BITS'(1));
  assign dout.overflowed = drop_flag;

  // control
  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    drop_flag_next  = drop_flag;
    unique case (state)
      ST_LOAD: begin
        if (in_beat) begin
          if (full) begin
            drop_flag_next = 1'b1;
          end else begin
            fill_count_next = fill_count + asi_pkg::CNT_BITS'(1);
          end
          if (din.is_final) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_beat) begin
          fill_count_next = fill_count - asi_pkg::CNT_BITS'(1);
          if (dout.run_end) begin
            state_next     = ST_LOAD;
            drop_flag_next = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      fill_count <= '0;
      drop_flag  <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      drop_flag  <= drop_flag_next;
    end
  end

  // checks
  a_drain_not_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> (fill_count != '0))
    else $error("drain with empty row");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= asi_pkg::CNT_BITS'(N))
    else $error("fill count beyond capacity");

  a_run_end_clears: assert property (@(posedge clk) disable iff (rst)
    (out_beat && dout.run_end) |=> (state == ST_LOAD && fill_count == '0 && !drop_flag))
    else $error("run end did not clear the row");

  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    (in_beat && !full) |=> (fill_count == $past(fill_count) + asi_pkg::CNT_BITS'(1)))
    else $error("insert did not advance fill count");

endmodule
`default_nettype wire
